// ===== design/tcgdr_pkg.sv =====
// shared types, constants and helpers for the text cell gray dither rasterizer
// no dependencies; imported by every module of the block

package tcgdr_pkg;

  localparam int CELL_W_DEF      = 8;
  localparam int CELL_H_DEF      = 16;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int PIX_W      = 8;
  localparam int RGB_W      = 24;
  localparam int SUM_W      = 16;
  localparam int LUMA_W     = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int IN_DATA_W  = 104;
  localparam int IN_USER_W  = 2;

  localparam logic [SUM_W-1:0] W_RED   = 16'd54;
  localparam logic [SUM_W-1:0] W_GREEN = 16'd182;
  localparam logic [SUM_W-1:0] W_BLUE  = 16'd19;
  // reciprocal of 255 scaled by 2**23, exact for sums up to 65535
  localparam logic [31:0] RECIP_255   = 32'h0000_8081;
  localparam int          RECIP_SHIFT = 23;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BLACK_LIMIT    = 3'd0,
    CFG_WHITE_LIMIT    = 3'd1,
    CFG_CURSOR_FG      = 3'd2,
    CFG_ACTIVE_CURSOR  = 3'd3,
    CFG_PASSIVE_CURSOR = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    KIND_HALF  = 2'd0,
    KIND_LEFT  = 2'd1,
    KIND_RIGHT = 2'd2,
    KIND_OTHER = 2'd3
  } width_kind_t;

  typedef enum logic [1:0] {
    BAND_BLACK  = 2'd0,
    BAND_DITHER = 2'd1,
    BAND_WHITE  = 2'd2
  } band_t;

  typedef struct packed {
    logic [LUMA_W-1:0] black_limit;
    logic [LUMA_W-1:0] white_limit;
    logic [RGB_W-1:0]  cursor_fg_rgb;
    logic [RGB_W-1:0]  active_cursor_rgb;
    logic [RGB_W-1:0]  passive_cursor_rgb;
  } cfg_t;

  typedef struct packed {
    logic [SUM_W-1:0] fg_sum;
    logic [SUM_W-1:0] bg_sum;
    logic [PIX_W-1:0] on_bits;
    logic             row_odd;
    logic             swap;
  } q_item_t;

endpackage

// ===== design/tcgdr_front.sv =====
// front end: cursor match, colour selection, weighted sums and glyph bit pick
// depends on tcgdr_pkg; feeds tcgdr_queue

module tcgdr_front #(
  parameter int CELL_W = tcgdr_pkg::CELL_W_DEF,
  parameter int CELL_H = tcgdr_pkg::CELL_H_DEF
) (
  input  tcgdr_pkg::cfg_t                     cfg,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [tcgdr_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic [tcgdr_pkg::IN_USER_W-1:0]     in_tuser,
  input  logic                                q_full,
  output logic                                q_push,
  output tcgdr_pkg::q_item_t                  q_item
);
  import tcgdr_pkg::*;

  localparam int GW_HALF  = CELL_W;
  localparam int GW_WIDE  = 2 * CELL_W;
  localparam int PAD_HALF = ((GW_HALF + 7) / 8) * 8 - GW_HALF;
  localparam int PAD_WIDE = ((GW_WIDE + 7) / 8) * 8 - GW_WIDE;
  localparam int PAD_LEFT = PAD_WIDE + CELL_W;
  localparam logic [5:0] LAST_ROW = 6'(CELL_H - 1);

  logic [RGB_W-1:0] fg_in, bg_in, fg_sel, bg_sel;
  logic [15:0]      glyph;
  logic [3:0]       row;
  width_kind_t      kind;
  logic             uline, shown, passive, hit;
  logic [7:0]       col, line, ccol, cline;
  logic [8:0]       col_p1, col_m1;

  function automatic logic glyph_bit(input logic [15:0] g, input int b);
    logic r;
    r = 1'b0;
    if (b >= 0 && b < 16) r = g[b[3:0]];
    return r;
  endfunction

  function automatic logic [SUM_W-1:0] wsum(input logic [RGB_W-1:0] c);
    logic [SUM_W-1:0] s;
    s = W_RED * SUM_W'(c[23:16]) + W_GREEN * SUM_W'(c[15:8]) + W_BLUE * SUM_W'(c[7:0]);
    return s;
  endfunction

  assign fg_in   = in_tdata[23:0];
  assign bg_in   = in_tdata[47:24];
  assign glyph   = in_tdata[63:48];
  assign row     = in_tdata[67:64];
  assign uline   = in_tdata[68];
  assign col     = in_tdata[76:69];
  assign line    = in_tdata[84:77];
  assign ccol    = in_tdata[92:85];
  assign cline   = in_tdata[100:93];
  assign shown   = in_tdata[101];
  assign passive = in_tdata[102];
  assign kind    = width_kind_t'(in_tuser);

  assign col_p1 = {1'b0, col} + 9'd1;
  assign col_m1 = {1'b0, col} - 9'd1;

  always_comb begin
    hit = shown && (line == cline) &&
          ((col == ccol) ||
           (kind == KIND_LEFT  && col_p1 == {1'b0, ccol}) ||
           (kind == KIND_RIGHT && col_m1 == {1'b0, ccol}));
    fg_sel = hit ? cfg.cursor_fg_rgb : fg_in;
    bg_sel = hit ? (passive ? cfg.passive_cursor_rgb : cfg.active_cursor_rgb) : bg_in;
  end

  always_comb begin
    q_item.on_bits = '0;
    for (int w = 0; w < PIX_W; w++) begin
      if (w < CELL_W) begin
        unique case (kind)
          KIND_HALF: q_item.on_bits[w] = glyph_bit(glyph, PAD_HALF + CELL_W - 1 - w);
          KIND_LEFT: q_item.on_bits[w] = glyph_bit(glyph, PAD_LEFT + CELL_W - 1 - w);
          default:   q_item.on_bits[w] = glyph_bit(glyph, PAD_WIDE + CELL_W - 1 - w);
        endcase
      end
    end
    q_item.fg_sum  = wsum(fg_sel);
    q_item.bg_sum  = wsum(bg_sel);
    q_item.row_odd = row[0];
    q_item.swap    = uline && ({2'b00, row} == LAST_ROW);
  end

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

endmodule

// ===== design/tcgdr_queue.sv =====
// short first-in first-out queue between front and back end, show-ahead read
// depends on tcgdr_pkg for the entry type

module tcgdr_queue #(
  parameter int DEPTH = tcgdr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  tcgdr_pkg::q_item_t push_item,
  output logic               full,
  input  logic               pop,
  output logic               not_empty,
  output tcgdr_pkg::q_item_t head_item
);
  import tcgdr_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  q_item_t          mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == FULL_CNT);
  assign not_empty = (cnt_r != '0);
  assign head_item = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    if (pop)  rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_item;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full && !pop |-> !push)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("queue read while empty");

endmodule

// ===== design/tcgdr_back.sv =====
// back end: luma by reciprocal multiply, banding, separation, underline, dither
// depends on tcgdr_pkg; drains tcgdr_queue and holds the output register

module tcgdr_back #(
  parameter int CELL_W = tcgdr_pkg::CELL_W_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  tcgdr_pkg::cfg_t              cfg,
  input  logic                         q_not_empty,
  input  tcgdr_pkg::q_item_t           q_head,
  output logic                         q_pop,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [tcgdr_pkg::PIX_W-1:0]  out_tdata
);
  import tcgdr_pkg::*;

  logic              s1_v_r, out_v_r;
  logic [LUMA_W-1:0] fl_r, bl_r, fl_nxt, bl_nxt;
  logic [PIX_W-1:0]  on_r;
  logic              row_odd_r, swap_r;
  logic [PIX_W-1:0]  pix_r, pix_nxt;
  logic [31:0]       fprod, bprod;
  logic              adv1, adv2;
  band_t             fgb, bgb, fgb_a, bgb_a, fgb_s, bgb_s, band;

  function automatic band_t band_of(input logic [LUMA_W-1:0] l, input cfg_t c);
    band_t b;
    if (l <= c.black_limit)     b = BAND_BLACK;
    else if (l < c.white_limit) b = BAND_DITHER;
    else                        b = BAND_WHITE;
    return b;
  endfunction

  function automatic band_t band_dn(input band_t b);
    band_t r;
    unique case (b)
      BAND_WHITE:  r = BAND_DITHER;
      BAND_DITHER: r = BAND_BLACK;
      default:     r = BAND_BLACK;
    endcase
    return r;
  endfunction

  function automatic band_t band_up(input band_t b);
    band_t r;
    unique case (b)
      BAND_BLACK:  r = BAND_DITHER;
      BAND_DITHER: r = BAND_WHITE;
      default:     r = BAND_WHITE;
    endcase
    return r;
  endfunction

  assign adv2  = !out_v_r || out_tready;
  assign adv1  = !s1_v_r || adv2;
  assign q_pop = q_not_empty && adv1;

  // sum / 255 as multiply by reciprocal
  assign fprod  = 32'(q_head.fg_sum) * RECIP_255;
  assign bprod  = 32'(q_head.bg_sum) * RECIP_255;
  assign fl_nxt = fprod[RECIP_SHIFT +: LUMA_W];
  assign bl_nxt = bprod[RECIP_SHIFT +: LUMA_W];

  always_comb begin
    fgb   = band_of(fl_r, cfg);
    bgb   = band_of(bl_r, cfg);
    fgb_a = fgb;
    bgb_a = bgb;
    if (fgb == bgb) begin
      if (fl_r < bl_r) begin
        if (fgb != BAND_BLACK) fgb_a = band_dn(fgb);
        else                   bgb_a = band_up(bgb);
      end else begin
        if (bgb != BAND_BLACK) bgb_a = band_dn(bgb);
        else                   fgb_a = band_up(fgb);
      end
    end
    fgb_s = swap_r ? bgb_a : fgb_a;
    bgb_s = swap_r ? fgb_a : bgb_a;
    pix_nxt = '0;
    for (int w = 0; w < PIX_W; w++) begin
      band = on_r[w] ? fgb_s : bgb_s;
      if (w < CELL_W) begin
        unique case (band)
          BAND_WHITE:  pix_nxt[w] = 1'b0;
          BAND_DITHER: pix_nxt[w] = row_odd_r ^ (w[0] == 1'b1);
          default:     pix_nxt[w] = 1'b1;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (adv1) s1_v_r <= q_not_empty;
      if (adv2) out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      fl_r      <= fl_nxt;
      bl_r      <= bl_nxt;
      on_r      <= q_head.on_bits;
      row_odd_r <= q_head.row_odd;
      swap_r    <= q_head.swap;
    end
    if (adv2 && s1_v_r) pix_r <= pix_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = pix_r;

  a_pop_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> s1_v_r)
    else $error("popped entry did not reach luma stage");

  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !adv2 |=> s1_v_r && $stable(fl_r) && $stable(bl_r))
    else $error("luma stage changed while blocked");

endmodule

// ===== design/text_cell_gray_dither_rasterizer_top.sv =====
// top level of the text cell gray dither rasterizer: config registers, front, queue, back
// depends on tcgdr_pkg, tcgdr_front, tcgdr_queue, tcgdr_back
//
// channel | direction | handshake          | payload
// in_     | in        | in_tvalid/tready   | in_tdata (cell fields), in_tuser (width kind)
// out_    | out       | out_tvalid/tready  | out_tdata (pixel row)
// cfg_    | in        | cfg_wr_en          | cfg_index, cfg_wdata
//
// one pixel row per cycle sustained while out_tready is high; an input transfer reaches
// output valid through the queue write, the luma multiply stage and the output register
// the reciprocal multiply feeds the luma stage register in the back end
// reset clears queue pointers and stage valids and loads register defaults
// output stalls back up through the queue; input is taken while the queue has room

module text_cell_gray_dither_rasterizer_top #(
  parameter int CELL_W      = tcgdr_pkg::CELL_W_DEF,
  parameter int CELL_H      = tcgdr_pkg::CELL_H_DEF,
  parameter int QUEUE_DEPTH = tcgdr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // fg_rgb, bg_rgb, glyph_row, row_index, underline, cell_col, cell_line,
  // cursor_col, cursor_line, cursor_shown, cursor_passive, zero pad
  input  logic [tcgdr_pkg::IN_DATA_W-1:0]   in_tdata,
  // width_kind
  input  logic [tcgdr_pkg::IN_USER_W-1:0]   in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // pixel_row
  output logic [tcgdr_pkg::PIX_W-1:0]       out_tdata,
  input  logic                              cfg_wr_en,
  input  logic [tcgdr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tcgdr_pkg::RGB_W-1:0]       cfg_wdata
);
  import tcgdr_pkg::*;

  cfg_t    cfg_r;
  q_item_t push_item, head_item;
  logic    q_push, q_full, q_pop, q_not_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.black_limit        <= 8'd85;
      cfg_r.white_limit        <= 8'd170;
      cfg_r.cursor_fg_rgb      <= 24'h000000;
      cfg_r.active_cursor_rgb  <= 24'hFFFFFF;
      cfg_r.passive_cursor_rgb <= 24'h808080;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_BLACK_LIMIT:    cfg_r.black_limit        <= cfg_wdata[LUMA_W-1:0];
        CFG_WHITE_LIMIT:    cfg_r.white_limit        <= cfg_wdata[LUMA_W-1:0];
        CFG_CURSOR_FG:      cfg_r.cursor_fg_rgb      <= cfg_wdata;
        CFG_ACTIVE_CURSOR:  cfg_r.active_cursor_rgb  <= cfg_wdata;
        CFG_PASSIVE_CURSOR: cfg_r.passive_cursor_rgb <= cfg_wdata;
        default: ;
      endcase
    end
  end

  tcgdr_front #(.CELL_W(CELL_W), .CELL_H(CELL_H)) u_front (
    .cfg       (cfg_r),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (push_item)
  );

  tcgdr_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_item (head_item)
  );

  tcgdr_back #(.CELL_W(CELL_W)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .q_not_empty (q_not_empty),
    .q_head      (head_item),
    .q_pop       (q_pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

endmodule

// ===== tb/tcgdr_checker.sv =====
// row predictor and scoreboard for the text cell gray dither rasterizer
// watches the input, result and register channels; depends on tcgdr_pkg
// keeps its own copy of the registers and reports a mismatch count to the testbench top

module tcgdr_checker #(
  parameter int CELL_W = 8,
  parameter int CELL_H = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  input  logic                              in_tready,
  input  logic [tcgdr_pkg::IN_DATA_W-1:0]   in_tdata,
  input  logic [tcgdr_pkg::IN_USER_W-1:0]   in_tuser,
  input  logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic [tcgdr_pkg::PIX_W-1:0]       out_tdata,
  input  logic                              cfg_wr_en,
  input  logic [tcgdr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tcgdr_pkg::RGB_W-1:0]       cfg_wdata,
  output int                                mismatches,
  output int                                pending
);
  import tcgdr_pkg::*;

  // in_tdata layout, lowest field last
  typedef struct packed {
    logic       zero_pad;
    logic       cursor_passive;
    logic       cursor_shown;
    logic [7:0] cursor_line;
    logic [7:0] cursor_col;
    logic [7:0] cell_line;
    logic [7:0] cell_col;
    logic       underline;
    logic [3:0] row_index;
    logic [15:0] glyph_row;
    logic [23:0] bg_rgb;
    logic [23:0] fg_rgb;
  } cell_fields_t;

  logic [LUMA_W-1:0] black_limit;
  logic [LUMA_W-1:0] white_limit;
  logic [RGB_W-1:0]  cursor_fg;
  logic [RGB_W-1:0]  active_cursor;
  logic [RGB_W-1:0]  passive_cursor;
  logic [PIX_W-1:0]  expected_rows[$];
  logic [PIX_W-1:0]  want_row;

  function automatic int luma_of(logic [RGB_W-1:0] rgb);
    return (54 * int'(rgb[23:16]) + 182 * int'(rgb[15:8]) + 19 * int'(rgb[7:0])) / 255;
  endfunction

  function automatic band_t band_of(int luma);
    if (luma <= int'(black_limit)) return BAND_BLACK;
    if (luma < int'(white_limit)) return BAND_DITHER;
    return BAND_WHITE;
  endfunction

  function automatic logic [PIX_W-1:0] render_row(cell_fields_t c, width_kind_t kind);
    logic [RGB_W-1:0] fg;
    logic [RGB_W-1:0] bg;
    int fl;
    int bl;
    int col;
    int ccol;
    int gwidth;
    int pad;
    int bit_idx;
    band_t fb;
    band_t bb;
    band_t swap_tmp;
    band_t pb;
    logic on;
    logic px;
    logic [PIX_W-1:0] row_bits;
    fg = c.fg_rgb;
    bg = c.bg_rgb;
    col = int'(c.cell_col);
    ccol = int'(c.cursor_col);
    row_bits = '0;
    // cursor cell, neighbors of wide cells included, no column wrap
    if (c.cursor_shown && c.cell_line == c.cursor_line &&
        (col == ccol || (kind == KIND_LEFT && col + 1 == ccol) ||
         (kind == KIND_RIGHT && col - 1 == ccol))) begin
      fg = cursor_fg;
      bg = c.cursor_passive ? passive_cursor : active_cursor;
    end
    fl = luma_of(fg);
    bl = luma_of(bg);
    fb = band_of(fl);
    bb = band_of(bl);
    // same band: push one color a step apart
    if (fb == bb) begin
      if (fl < bl) begin
        if (fb != BAND_BLACK) fb = band_t'(fb - 1);
        else bb = band_t'(bb + 1);
      end else begin
        if (bb != BAND_BLACK) bb = band_t'(bb - 1);
        else fb = band_t'(fb + 1);
      end
    end
    if (c.underline && int'(c.row_index) == CELL_H - 1) begin
      swap_tmp = fb;
      fb = bb;
      bb = swap_tmp;
    end
    gwidth = (kind == KIND_HALF) ? CELL_W : 2 * CELL_W;
    pad = ((gwidth + 7) / 8) * 8 - gwidth;
    if (kind == KIND_LEFT) pad += CELL_W;
    for (int w = 0; w < CELL_W && w < PIX_W; w++) begin
      bit_idx = pad + CELL_W - 1 - w;
      on = (bit_idx < 16) ? c.glyph_row[bit_idx] : 1'b0;
      pb = on ? fb : bb;
      if (pb == BAND_WHITE) px = 1'b0;
      else if (pb == BAND_DITHER) px = (c.row_index[0] == w[0]) ? 1'b0 : 1'b1;
      else px = 1'b1;
      row_bits[w] = px;
    end
    return row_bits;
  endfunction

  task automatic note_mismatch(input logic [PIX_W-1:0] want, input logic [PIX_W-1:0] got,
                               input logic none_waiting);
    mismatches++;
    if (mismatches <= 10) begin
      if (none_waiting) $display("mismatch: no pixel row expected, got %02h", got);
      else $display("mismatch: pixel_row expected %02h, got %02h", want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      black_limit    = 8'd85;
      white_limit    = 8'd170;
      cursor_fg      = 24'h000000;
      active_cursor  = 24'hFFFFFF;
      passive_cursor = 24'h808080;
      expected_rows.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_BLACK_LIMIT:    black_limit = cfg_wdata[LUMA_W-1:0];
          CFG_WHITE_LIMIT:    white_limit = cfg_wdata[LUMA_W-1:0];
          CFG_CURSOR_FG:      cursor_fg = cfg_wdata;
          CFG_ACTIVE_CURSOR:  active_cursor = cfg_wdata;
          CFG_PASSIVE_CURSOR: passive_cursor = cfg_wdata;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        expected_rows.push_back(render_row(cell_fields_t'(in_tdata), width_kind_t'(in_tuser)));
      if (out_tvalid && out_tready) begin
        if (expected_rows.size() == 0) begin
          note_mismatch('0, out_tdata, 1'b1);
        end else begin
          want_row = expected_rows.pop_front();
          if (want_row !== out_tdata) note_mismatch(want_row, out_tdata, 1'b0);
        end
      end
    end
    pending = expected_rows.size();
  end

endmodule

// ===== tb/tb.sv =====
// testbench top for the text cell gray dither rasterizer: clock, reset, stimulus and verdict
// depends on tcgdr_pkg, text_cell_gray_dither_rasterizer_top and tcgdr_checker
// directed rows first, then random rows over several register settings with random stalls

module tb;
  import tcgdr_pkg::*;

  localparam int CELL_W        = 8;
  localparam int CELL_H        = 16;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 6;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  // fg_rgb, bg_rgb, glyph_row, row_index, underline, cell_col, cell_line,
  // cursor_col, cursor_line, cursor_shown, cursor_passive, zero pad
  logic [IN_DATA_W-1:0] in_tdata;
  // width_kind
  logic [IN_USER_W-1:0] in_tuser;
  logic                 out_tvalid;
  logic                 out_tready;
  // pixel_row
  logic [PIX_W-1:0]     out_tdata;
  logic                 cfg_wr_en;
  cfg_idx_t             cfg_index;
  logic [RGB_W-1:0]     cfg_wdata;

  int          mismatches;
  int          pending;
  int          hold_token;
  logic        quiet;
  logic [7:0]  lim_lo;
  logic [7:0]  lim_hi;
  int unsigned cycle_count = 0;

  text_cell_gray_dither_rasterizer_top #(
    .CELL_W(CELL_W),
    .CELL_H(CELL_H)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  tcgdr_checker #(
    .CELL_W(CELL_W),
    .CELL_H(CELL_H)
  ) u_checker (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .mismatches(mismatches),
    .pending(pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic [IN_DATA_W-1:0] make_cell(
    input logic [23:0] fg, input logic [23:0] bg, input logic [15:0] glyph,
    input logic [3:0] row, input logic ul, input logic [7:0] col, input logic [7:0] line,
    input logic [7:0] ccol, input logic [7:0] cline, input logic shown, input logic passive);
    return {1'b0, passive, shown, cline, ccol, line, col, ul, row, glyph, bg, fg};
  endfunction

  function automatic logic [23:0] pick_rgb();
    logic [7:0] g;
    case ($urandom_range(5))
      0: return 24'h000000;
      1: return 24'hFFFFFF;
      2: begin
        g = lim_lo + 8'($urandom_range(2)) - 8'd1;
        return {g, g, g};
      end
      3: begin
        g = lim_hi + 8'($urandom_range(2)) - 8'd1;
        return {g, g, g};
      end
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic send_cell(input logic [IN_DATA_W-1:0] data, input width_kind_t kind);
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    in_tuser  <= kind;
    do @(posedge clk); while (!in_tready);
    if (!quiet) begin
      while ($urandom_range(99) < 28) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
  endtask

  // drop valid and wait until every expected row has come out
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [RGB_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_all(input logic [7:0] blk, input logic [7:0] wht,
                           input logic [23:0] cur_fg, input logic [23:0] act,
                           input logic [23:0] pas);
    settle();
    write_reg(CFG_BLACK_LIMIT, 24'(blk));
    write_reg(CFG_WHITE_LIMIT, 24'(wht));
    write_reg(CFG_CURSOR_FG, cur_fg);
    write_reg(CFG_ACTIVE_CURSOR, act);
    write_reg(CFG_PASSIVE_CURSOR, pas);
    lim_lo = blk;
    lim_hi = wht;
  endtask

  task automatic send_random_cell();
    logic [7:0]  col;
    logic [7:0]  line;
    logic [7:0]  ccol;
    logic [7:0]  cline;
    logic [3:0]  row;
    width_kind_t kind;
    kind  = ($urandom_range(9) == 0) ? KIND_OTHER : width_kind_t'($urandom_range(2));
    row   = ($urandom_range(3) == 0) ? 4'd15 : 4'($urandom_range(15));
    ccol  = 8'($urandom);
    cline = 8'($urandom);
    line  = ($urandom_range(2) != 0) ? cline : 8'($urandom);
    // bias toward the cursor column and its neighbors
    case ($urandom_range(3))
      0: col = ccol;
      1: col = ccol - 8'd1;
      2: col = ccol + 8'd1;
      default: col = 8'($urandom);
    endcase
    send_cell(make_cell(pick_rgb(), pick_rgb(), 16'($urandom), row, 1'($urandom), col, line,
                        ccol, cline, $urandom_range(3) != 0, 1'($urandom)), kind);
  endtask

  task automatic run_random(input int count);
    for (int i = 0; i < count; i++) send_random_cell();
  endtask

  task automatic run_directed();
    // extremes and same-band cases
    send_cell(make_cell(24'h000000, 24'hFFFFFF, 16'hFFFF, 4'd0, 1'b0, 8'd1, 8'd1, 8'd9, 8'd9,
                        1'b0, 1'b0), KIND_HALF);
    send_cell(make_cell(24'hFFFFFF, 24'h000000, 16'h00FF, 4'd1, 1'b0, 8'd1, 8'd1, 8'd9, 8'd9,
                        1'b0, 1'b0), KIND_HALF);
    send_cell(make_cell(24'hFFFFFF, 24'hFFFFFF, 16'hF0F0, 4'd2, 1'b0, 8'd1, 8'd1, 8'd9, 8'd9,
                        1'b0, 1'b0), KIND_HALF);
    send_cell(make_cell(24'h000000, 24'h101010, 16'h0F0F, 4'd3, 1'b0, 8'd1, 8'd1, 8'd9, 8'd9,
                        1'b0, 1'b0), KIND_HALF);
    send_cell(make_cell(24'h707070, 24'h909090, 16'h3C3C, 4'd4, 1'b0, 8'd1, 8'd1, 8'd9, 8'd9,
                        1'b0, 1'b0), KIND_HALF);
    send_cell(make_cell(24'hC0C0C0, 24'hF0F0F0, 16'h5A5A, 4'd5, 1'b0, 8'd1, 8'd1, 8'd9, 8'd9,
                        1'b0, 1'b0), KIND_HALF);
    // underline on the last row and the row above it
    send_cell(make_cell(24'h000000, 24'hFFFFFF, 16'h00C3, 4'd15, 1'b1, 8'd2, 8'd2, 8'd9, 8'd9,
                        1'b0, 1'b0), KIND_HALF);
    send_cell(make_cell(24'h000000, 24'hFFFFFF, 16'h00C3, 4'd14, 1'b1, 8'd2, 8'd2, 8'd9, 8'd9,
                        1'b0, 1'b0), KIND_HALF);
    // width kinds
    send_cell(make_cell(24'h000000, 24'h808080, 16'hAA55, 4'd6, 1'b0, 8'd3, 8'd3, 8'd9, 8'd9,
                        1'b0, 1'b0), KIND_LEFT);
    send_cell(make_cell(24'h000000, 24'h808080, 16'hAA55, 4'd7, 1'b0, 8'd3, 8'd3, 8'd9, 8'd9,
                        1'b0, 1'b0), KIND_RIGHT);
    send_cell(make_cell(24'h000000, 24'h808080, 16'hAA55, 4'd8, 1'b0, 8'd3, 8'd3, 8'd9, 8'd9,
                        1'b0, 1'b0), KIND_OTHER);
    // cursor cell: active, passive, hidden
    send_cell(make_cell(24'h00FF00, 24'h0000FF, 16'h1234, 4'd9, 1'b0, 8'd10, 8'd5, 8'd10, 8'd5,
                        1'b1, 1'b0), KIND_HALF);
    send_cell(make_cell(24'h00FF00, 24'h0000FF, 16'h1234, 4'd9, 1'b0, 8'd10, 8'd5, 8'd10, 8'd5,
                        1'b1, 1'b1), KIND_HALF);
    send_cell(make_cell(24'h00FF00, 24'h0000FF, 16'h1234, 4'd9, 1'b0, 8'd10, 8'd5, 8'd10, 8'd5,
                        1'b0, 1'b0), KIND_HALF);
    // wide cell neighbors of the cursor
    send_cell(make_cell(24'hFF0000, 24'h00FFFF, 16'h8001, 4'd10, 1'b0, 8'd10, 8'd5, 8'd11, 8'd5,
                        1'b1, 1'b0), KIND_LEFT);
    send_cell(make_cell(24'hFF0000, 24'h00FFFF, 16'h8001, 4'd11, 1'b0, 8'd12, 8'd5, 8'd11, 8'd5,
                        1'b1, 1'b1), KIND_RIGHT);
    send_cell(make_cell(24'hFF0000, 24'h00FFFF, 16'h8001, 4'd12, 1'b0, 8'd10, 8'd5, 8'd11, 8'd5,
                        1'b1, 1'b0), KIND_OTHER);
    // column ends do not wrap
    send_cell(make_cell(24'hFFFFFF, 24'hFFFFFF, 16'hC00C, 4'd13, 1'b0, 8'd0, 8'd7, 8'd255, 8'd7,
                        1'b1, 1'b0), KIND_RIGHT);
    send_cell(make_cell(24'hFFFFFF, 24'hFFFFFF, 16'hC00C, 4'd13, 1'b0, 8'd255, 8'd7, 8'd0, 8'd7,
                        1'b1, 1'b1), KIND_LEFT);
    // cursor column but a different line
    send_cell(make_cell(24'h404040, 24'hE0E0E0, 16'h7E7E, 4'd0, 1'b0, 8'd20, 8'd6, 8'd20, 8'd7,
                        1'b1, 1'b0), KIND_HALF);
    // every field at its top and at zero
    send_cell(make_cell(24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 4'd15, 1'b1, 8'd255, 8'd255, 8'd255,
                        8'd255, 1'b1, 1'b1), KIND_OTHER);
    send_cell(make_cell(24'h000000, 24'h000000, 16'h0000, 4'd0, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0,
                        1'b0, 1'b0), KIND_HALF);
  endtask

  initial begin : receiver
    int hold_seen;
    hold_seen = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_tready <= quiet || ($urandom_range(99) >= 28);
    end
  end

  initial begin
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= KIND_HALF;
    cfg_wr_en  <= 1'b0;
    cfg_index  <= CFG_BLACK_LIMIT;
    cfg_wdata  <= '0;
    quiet      <= 1'b0;
    hold_token <= 0;
    lim_lo = 8'd85;
    lim_hi = 8'd170;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    run_directed();
    run_random(200);

    // widest dither band, cursor colors at the extremes
    write_all(8'd0, 8'd255, 24'hFFFFFF, 24'h000000, 24'h000000);
    run_random(100);
    hold_token <= hold_token + 1;
    run_random(100);

    // crossed limits: no dither band
    write_all(8'd255, 8'd0, 24'h808080, 24'h123456, 24'hFEDCBA);
    run_random(100);
    settle();
    run_random(100);

    // adjacent limits leave the dither band empty, no idling on either side
    write_all(8'd100, 8'd101, 24'hFFFFFF, 24'hFFFFFF, 24'h000000);
    quiet <= 1'b1;
    run_random(150);
    quiet <= 1'b0;

    write_all(8'($urandom), 8'($urandom), 24'($urandom), 24'($urandom), 24'($urandom));
    run_random(150);

    write_all(8'd0, 8'd0, 24'h000000, 24'h000000, 24'hFFFFFF);
    run_random(100);

    settle();
    if (mismatches == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
